// ----- design/mtlr_pkg.sv -----
// mtlr_pkg: shared types, constants and trie tables of the media type list recognizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package mtlr_pkg;

    localparam int MAX_LIST = 64;
    localparam logic [7:0] MAX_LIST_B = 8'(MAX_LIST);

    localparam int TYPE_NODES = 30;
    localparam int SUB_NODES  = 127;

    localparam logic [2:0] TYPE_WILD = 3'd5;
    localparam logic [4:0] SUB_WILD  = 5'd16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SYNTAX   = 3'd1;
    localparam logic [2:0] ST_WILD_SUB = 3'd2;
    localparam logic [2:0] ST_SINGLE   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_COMMA = 8'h2c;

    localparam logic [8*TYPE_NODES-1:0] TYPE_CHARS = "textmessageultipartapplication";
    localparam logic [8*SUB_NODES-1:0] SUB_CHARS = {
        "plainidf+xmlsdpimple-message-summarycpiml+xmlrlmi+xmlelated",
        "lpidf+xmlwatcherinfo+xmlxpidf+xmlml+msrtc.pidfexternal-bodymixedisup"};

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_last;
    } t_in;

    typedef struct packed {
        logic [2:0] type_code;
        logic [4:0] subtype_code;
        logic [2:0] status;
        logic [7:0] entry_index;
        logic       list_done;
    } t_out;

    typedef enum logic [6:0] {
        PH_LEAD       = 7'b0000001,
        PH_TYPE       = 7'b0000010,
        PH_AFTER_TYPE = 7'b0000100,
        PH_BEFORE_SUB = 7'b0001000,
        PH_SUB        = 7'b0010000,
        PH_AFTER_SUB  = 7'b0100000,
        PH_PARAM      = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic load;
        logic eval;
        logic walk;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic need_walk;
        logic walk_done;
        logic fin_result;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic       valid;
        t_out       res;
        logic [2:0] err;
        logic       inc;
    } t_ee;

    function automatic logic [7:0] type_char(input logic [6:0] i);
        logic [7:0] r;
        r = 8'h00;
        if (int'(i) < TYPE_NODES) r = TYPE_CHARS[8*(TYPE_NODES-1-int'(i)) +: 8];
        return r;
    endfunction

    function automatic logic [7:0] sub_char(input logic [6:0] i);
        logic [7:0] r;
        r = 8'h00;
        if (int'(i) < SUB_NODES) r = SUB_CHARS[8*(SUB_NODES-1-int'(i)) +: 8];
        return r;
    endfunction

    function automatic logic [6:0] type_link(input logic [6:0] i);
        logic [6:0] r;
        case (i)
            7'd0:    r = 7'd4;
            7'd4:    r = 7'd19;
            7'd5:    r = 7'd11;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] sub_link(input logic [6:0] i);
        logic [6:0] r;
        case (i)
            7'd0:    r = 7'd12;
            7'd1:    r = 7'd5;
            7'd12:   r = 7'd36;
            7'd13:   r = 7'd15;
            7'd36:   r = 7'd45;
            7'd38:   r = 7'd40;
            7'd45:   r = 7'd59;
            7'd46:   r = 7'd53;
            7'd59:   r = 7'd68;
            7'd68:   r = 7'd83;
            7'd83:   r = 7'd105;
            7'd84:   r = 7'd92;
            7'd105:  r = 7'd118;
            7'd118:  r = 7'd123;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] type_final(input logic [6:0] i);
        logic [2:0] r;
        case (i)
            7'd3:    r = 3'd1;
            7'd10:   r = 3'd2;
            7'd18:   r = 3'd4;
            7'd29:   r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] sub_final(input logic [6:0] i);
        logic [4:0] r;
        case (i)
            7'd4:    r = 5'd1;
            7'd11:   r = 5'd2;
            7'd14:   r = 5'd3;
            7'd35:   r = 5'd4;
            7'd39:   r = 5'd5;
            7'd44:   r = 5'd6;
            7'd52:   r = 5'd7;
            7'd58:   r = 5'd8;
            7'd67:   r = 5'd9;
            7'd82:   r = 5'd10;
            7'd91:   r = 5'd11;
            7'd104:  r = 5'd12;
            7'd117:  r = 5'd13;
            7'd122:  r = 5'd14;
            7'd126:  r = 5'd15;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] type_code_of(input logic [5:0] st);
        logic [2:0] r;
        r = 3'd0;
        if (st != 6'd0) r = type_final(7'(st) - 7'd1);
        return r;
    endfunction

    function automatic logic [4:0] sub_code_of(input logic [6:0] st);
        logic [4:0] r;
        r = 5'd0;
        if (st != 7'd0) r = sub_final(st - 7'd1);
        return r;
    endfunction

    function automatic logic char_match(input logic [7:0] c, input logic [7:0] ref_c);
        logic [7:0] low;
        logic       r;
        low = c | 8'h20;
        if (low >= 8'h61 && low <= 8'h7a) r = (low == ref_c);
        else r = (c == ref_c);
        return r;
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h41 && c <= 8'h5a) || c == 8'h2d || c == 8'h2b || c == 8'h2e;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic logic held_is_space(input logic [7:0] h, input logic [7:0] nxt);
        logic r;
        if (h == CH_CR) r = (nxt == CH_LF);
        else r = (h == CH_LF) && is_blank(nxt);
        return r;
    endfunction

    // closes one type entry; err is ST_OK when nothing is latched
    function automatic t_ee entry_end(input logic [2:0] t, input logic tok,
                                      input logic [6:0] snode, input logic mode,
                                      input logic [7:0] count, input logic comma,
                                      input logic last);
        t_ee        r;
        logic [4:0] s;
        r = '0;
        s = tok ? sub_code_of(snode) : SUB_WILD;
        if (t == TYPE_WILD && s != SUB_WILD) begin
            r.err = ST_WILD_SUB;
        end else if (mode) begin
            if (comma || t == TYPE_WILD || s == SUB_WILD) begin
                r.err = ST_SINGLE;
            end else begin
                r.valid = 1'b1;
                r.res   = '{type_code: t, subtype_code: s, status: ST_OK,
                            entry_index: 8'd0, list_done: 1'b1};
            end
        end else if (count >= MAX_LIST_B) begin
            r.err = ST_OVERFLOW;
        end else if (comma && last) begin
            r.err = ST_SYNTAX;
        end else begin
            r.valid = 1'b1;
            r.res   = '{type_code: t, subtype_code: s, status: ST_OK,
                        entry_index: count, list_done: !comma};
            r.inc   = comma;
        end
        return r;
    endfunction

endpackage

// ----- design/mtlr_ctrl.sv -----
// mtlr_ctrl: sequencer of the recognizer: accept, evaluate, trie walk, finish.
// Depends on mtlr_pkg for the command and status structs.
`timescale 1ns / 1ps
module mtlr_ctrl import mtlr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_WALK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   fin_go;

    assign o_in_ready = (r_state == S_IDLE);
    // a finish with a result waits for room in the output register
    assign fin_go = !i_stat.fin_result || i_stat.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.need_walk ? S_WALK : S_FIN;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EVAL)
        else $error("load not followed by eval");
    a_walk_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_stat.walk_done) |=> r_state == S_FIN)
        else $error("walk end not followed by finish");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && fin_go) |=> r_state == S_IDLE)
        else $error("finish did not return to idle");

endmodule

// ----- design/mtlr_dp.sv -----
// mtlr_dp: parse state, trie walker and result registers of the recognizer.
// Depends on mtlr_pkg; driven by mtlr_ctrl commands.
`timescale 1ns / 1ps
module mtlr_dp import mtlr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in      i_in_data,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out     o_out_data
);

    logic       r_mode;
    logic [7:0] r_byte;
    logic       r_last;
    t_phase     r_phase, n_phase;
    logic [5:0] r_tnode, n_tnode;
    logic [6:0] r_snode, n_snode;
    logic [2:0] r_ltype, n_ltype;
    logic [7:0] r_held, n_held;
    logic       r_held_v, n_held_v;
    logic       r_tok, n_tok;
    logic [7:0] r_count, n_count;
    logic [2:0] r_err, n_err;
    logic [6:0] r_cand, n_cand;
    logic       r_walk_sub, n_walk_sub;
    logic       r_pend_v, n_pend_v;
    t_out       r_pend, n_pend;
    logic       r_out_v;
    t_out       r_out;

    logic       walk_req;
    logic       walk_done;
    logic       fin_v;
    t_out       fin_res;

    // walk step and finish values
    logic [6:0] w_size, w_link, w_node;
    logic [7:0] w_char;
    logic [2:0] f_err;
    t_ee        f_ee;

    always_comb begin
        w_size    = r_walk_sub ? 7'(SUB_NODES) : 7'(TYPE_NODES);
        w_char    = r_walk_sub ? sub_char(r_cand) : type_char(r_cand);
        w_link    = r_walk_sub ? sub_link(r_cand) : type_link(r_cand);
        walk_done = 1'b1;
        w_node    = 7'd0;
        if (r_cand >= w_size) begin
            w_node = 7'd0;
        end else if (char_match(r_byte, w_char)) begin
            w_node = r_cand + 7'd1;
        end else if (w_link != 7'd0) begin
            walk_done = 1'b0;
        end
    end

    always_comb begin
        f_err   = r_err;
        fin_v   = r_pend_v;
        fin_res = r_pend;
        f_ee    = entry_end(r_ltype, r_tok, r_snode, r_mode, r_count, 1'b0, 1'b1);
        if (r_last) begin
            if (r_err == ST_OK && !r_pend_v) begin
                if (r_phase == PH_SUB || r_phase == PH_AFTER_SUB || r_phase == PH_PARAM) begin
                    fin_v   = f_ee.valid;
                    fin_res = f_ee.res;
                    f_err   = f_ee.err;
                end else begin
                    f_err = ST_SYNTAX;
                end
            end
            if (f_err != ST_OK) begin
                fin_v   = 1'b1;
                fin_res = '{type_code: 3'd0, subtype_code: 5'd0, status: f_err,
                            entry_index: r_count, list_done: 1'b1};
            end
        end
    end

    always_comb begin
        t_phase     ph;
        logic       go;
        logic [2:0] e;
        logic [7:0] c;
        t_ee        ee;
        n_phase    = r_phase;
        n_tnode    = r_tnode;
        n_snode    = r_snode;
        n_ltype    = r_ltype;
        n_held     = r_held;
        n_held_v   = r_held_v;
        n_tok      = r_tok;
        n_count    = r_count;
        n_err      = r_err;
        n_cand     = r_cand;
        n_walk_sub = r_walk_sub;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        walk_req   = 1'b0;
        c          = r_byte;
        e          = r_err;
        ph         = r_phase;
        go         = 1'b1;
        ee         = entry_end(r_ltype, r_tok, r_snode, r_mode, r_count, 1'b1, r_last);

        if (i_cmd.eval) begin
            n_held_v = 1'b0;
            n_pend_v = 1'b0;
            if (r_held_v && e == ST_OK && !held_is_space(r_held, c)) e = ST_SYNTAX;
            if (e == ST_OK) begin
                if (ph == PH_TYPE) begin
                    if (name_char(c)) begin
                        go = 1'b0;
                        if (r_tnode == 6'd0 || type_final(7'(r_tnode) - 7'd1) != 3'd0) begin
                            n_tnode = 6'd0;
                        end else begin
                            walk_req   = 1'b1;
                            n_cand     = 7'(r_tnode);
                            n_walk_sub = 1'b0;
                        end
                    end else begin
                        n_ltype = type_code_of(r_tnode);
                        n_tok   = 1'b0;
                        ph      = PH_AFTER_TYPE;
                    end
                end
                if (ph == PH_SUB) begin
                    if (name_char(c) || c == CH_UNDER) begin
                        go = 1'b0;
                        if (r_snode == 7'd0 || sub_final(r_snode - 7'd1) != 5'd0) begin
                            n_snode = 7'd0;
                        end else begin
                            walk_req   = 1'b1;
                            n_cand     = r_snode;
                            n_walk_sub = 1'b1;
                        end
                    end else begin
                        ph = PH_AFTER_SUB;
                    end
                end
                n_phase = ph;
                if (go) begin
                    unique case (ph)
                        PH_LEAD: begin
                            if (is_blank(c)) begin
                            end else if ((c == CH_CR || c == CH_LF) && !r_last) begin
                                n_held = c;
                                n_held_v = 1'b1;
                            end else if (c == CH_STAR) begin
                                n_ltype = TYPE_WILD;
                                n_phase = PH_AFTER_TYPE;
                            end else if (name_char(c)) begin
                                n_tok      = 1'b1;
                                walk_req   = 1'b1;
                                n_cand     = 7'd0;
                                n_walk_sub = 1'b0;
                                n_phase    = PH_TYPE;
                            end else begin
                                e = ST_SYNTAX;
                            end
                        end
                        PH_AFTER_TYPE: begin
                            if (is_blank(c)) begin
                            end else if (c == CH_LF && !r_last) begin
                                n_held = c;
                                n_held_v = 1'b1;
                            end else if (c == CH_SLASH) begin
                                n_phase = PH_BEFORE_SUB;
                            end else begin
                                e = ST_SYNTAX;
                            end
                        end
                        PH_BEFORE_SUB: begin
                            if (is_blank(c)) begin
                            end else if (c == CH_LF && !r_last) begin
                                n_held = c;
                                n_held_v = 1'b1;
                            end else if (c == CH_STAR) begin
                                n_tok   = 1'b0;
                                n_phase = PH_AFTER_SUB;
                            end else if (name_char(c) || c == CH_UNDER) begin
                                n_tok      = 1'b1;
                                walk_req   = 1'b1;
                                n_cand     = 7'd0;
                                n_walk_sub = 1'b1;
                                n_phase    = PH_SUB;
                            end else begin
                                e = ST_SYNTAX;
                            end
                        end
                        PH_AFTER_SUB, PH_PARAM: begin
                            if (ph == PH_AFTER_SUB && is_blank(c)) begin
                            end else if (ph == PH_AFTER_SUB && c == CH_LF && !r_last) begin
                                n_held = c;
                                n_held_v = 1'b1;
                            end else if (ph == PH_AFTER_SUB && c == CH_SEMI) begin
                                n_phase = PH_PARAM;
                            end else if (c == CH_COMMA) begin
                                n_pend_v = ee.valid;
                                n_pend   = ee.res;
                                if (ee.err != ST_OK) e = ee.err;
                                if (ee.inc) begin
                                    n_count  = r_count + 8'd1;
                                    n_phase  = PH_LEAD;
                                    n_tnode  = 6'd0;
                                    n_snode  = 7'd0;
                                    n_ltype  = 3'd0;
                                    n_held   = 8'd0;
                                    n_held_v = 1'b0;
                                    n_tok    = 1'b0;
                                end
                            end else if (ph == PH_AFTER_SUB) begin
                                e = ST_SYNTAX;
                            end
                        end
                        default: e = ST_SYNTAX;
                    endcase
                end
            end
            n_err = e;
        end else if (i_cmd.walk) begin
            n_cand = w_link;
            if (walk_done) begin
                if (r_walk_sub) n_snode = w_node;
                else n_tnode = w_node[5:0];
            end
        end else if (i_cmd.fin) begin
            n_pend_v = 1'b0;
            n_err    = f_err;
            if (r_last) begin
                n_phase  = PH_LEAD;
                n_tnode  = 6'd0;
                n_snode  = 7'd0;
                n_ltype  = 3'd0;
                n_held   = 8'd0;
                n_held_v = 1'b0;
                n_tok    = 1'b0;
                n_count  = 8'd0;
                n_err    = ST_OK;
            end
        end
    end

    assign o_stat.need_walk  = walk_req;
    assign o_stat.walk_done  = walk_done;
    assign o_stat.fin_result = fin_v;
    assign o_stat.out_free   = !r_out_v || i_out_ready;
    assign o_out_valid       = r_out_v;
    assign o_out_data        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_phase    <= PH_LEAD;
            r_tnode    <= 6'd0;
            r_snode    <= 7'd0;
            r_ltype    <= 3'd0;
            r_held     <= 8'd0;
            r_held_v   <= 1'b0;
            r_tok      <= 1'b0;
            r_count    <= 8'd0;
            r_err      <= ST_OK;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_walk_sub <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            r_phase    <= n_phase;
            r_tnode    <= n_tnode;
            r_snode    <= n_snode;
            r_ltype    <= n_ltype;
            r_held     <= n_held;
            r_held_v   <= n_held_v;
            r_tok      <= n_tok;
            r_count    <= n_count;
            r_err      <= n_err;
            r_pend_v   <= n_pend_v;
            r_walk_sub <= n_walk_sub;
            if (i_cmd.fin && fin_v) r_out_v <= 1'b1;
            else if (i_out_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_pend <= n_pend;
        if (i_cmd.load) begin
            r_byte <= i_in_data.body_byte;
            r_last <= i_in_data.body_last;
        end
        if (i_cmd.fin && fin_v) r_out <= fin_res;
    end

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status != ST_OK) |->
        (r_out.type_code == 3'd0 && r_out.subtype_code == 5'd0 && r_out.list_done))
        else $error("error result carries a type");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && r_last) |=> (r_count == 8'd0 && r_err == ST_OK && r_phase == PH_LEAD))
        else $error("state not cleared after last byte");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_LIST_B)
        else $error("entry count beyond limit");

endmodule

// ----- design/media_type_list_recognizer_core.sv -----
// Media type list recognizer: bytes of a header body in, one result per media type out.
// Holds the parse state in a FSM-sequenced datapath and walks two fixed name tries.
// Input channel i_in_valid/o_in_ready carries one body byte and a last flag per request.
// Output channel o_out_valid/i_out_ready carries type, subtype, status, entry index and
// a done flag. A request gives at most one result: at a ',' that closes a type in list
// mode, and always at the last byte (errors latch and are reported there).
// Each request passes through accept, evaluate and finish, plus one trie walk step per
// node compared when the byte extends a name, at most 10 nodes in the subtype trie.
// The result is registered at finish, which waits while an earlier result is still held.
// The output register frees the input side: a new request is taken while a result
// waits, and only a second result stalls the sequencer until the receiver takes the first.
// i_cfg_we/i_cfg_wdata set single-type mode; write only while idle.
// Synchronous active-low reset clears parse state, the mode and the output valid.
`timescale 1ns / 1ps
module media_type_list_recognizer_core import mtlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mtlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mtlr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- verif/media_type_list_recognizer_core_tb.sv -----
// Testbench for media_type_list_recognizer_core: drives header bodies byte by byte and
// checks every result against a predictor of the parser kept in this file.
// Depends on mtlr_pkg (payload structs, phase enum, status and character codes).
`timescale 1ns / 1ps
module media_type_list_recognizer_core_tb;
    import mtlr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    media_type_list_recognizer_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic       mode_single;
    t_phase     phase;
    int         tnode, snode;
    logic [2:0] cur_type;
    logic [7:0] pending_ws;
    logic       pending_ws_v;
    logic       name_open;
    logic [7:0] types_seen;
    logic [2:0] err_code;
    logic       res_v;
    t_out       res;

    t_out       expected_results[$];
    logic [7:0] body[$];
    int         fail_count = 0;
    int         bytes_sent = 0;
    int         results_seen = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         quiet_cycles = 0;

    string TYPE_ROM = "textmessageultipartapplication";
    string SUB_ROM  = {"plainidf+xmlsdpimple-message-summarycpiml+xmlrlmi+xmlelated",
                       "lpidf+xmlwatcherinfo+xmlxpidf+xmlml+msrtc.pidfexternal-bodymixedisup"};

    function automatic int rom_next(bit sub, int n);
        int r;
        r = 0;
        if (!sub) begin
            case (n) 0: r = 4; 4: r = 19; 5: r = 11; default: r = 0; endcase
        end else begin
            case (n)
                0: r = 12;    1: r = 5;     12: r = 36;  13: r = 15;  36: r = 45;
                38: r = 40;   45: r = 59;   46: r = 53;  59: r = 68;  68: r = 83;
                83: r = 105;  84: r = 92;   105: r = 118; 118: r = 123;
                default: r = 0;
            endcase
        end
        return r;
    endfunction

    function automatic int rom_code(bit sub, int n);
        int r;
        r = 0;
        if (!sub) begin
            case (n) 3: r = 1; 10: r = 2; 18: r = 4; 29: r = 3; default: r = 0; endcase
        end else begin
            case (n)
                4: r = 1;   11: r = 2;  14: r = 3;  35: r = 4;  39: r = 5;
                44: r = 6;  52: r = 7;  58: r = 8;  67: r = 9;  82: r = 10;
                91: r = 11; 104: r = 12; 117: r = 13; 122: r = 14; 126: r = 15;
                default: r = 0;
            endcase
        end
        return r;
    endfunction

    function automatic int name_code(bit sub, int st);
        return (st == 0) ? 0 : rom_code(sub, st - 1);
    endfunction

    function automatic bit is_name(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == "-" || c == "+" || c == ".";
    endfunction

    function automatic bit same_letter(logic [7:0] c, logic [7:0] r);
        logic [7:0] lo;
        lo = c | 8'h20;
        if (lo >= "a" && lo <= "z") return lo == r;
        return c == r;
    endfunction

    // one step through a trie; 0 means no node matched
    function automatic int trie_step(bit sub, int st, bit fresh, logic [7:0] c);
        int size, cand;
        size = sub ? SUB_NODES : TYPE_NODES;
        cand = 0;
        if (!fresh) begin
            if (st == 0 || st > size) return 0;
            if (rom_code(sub, st - 1) != 0) return 0;
            cand = st;
        end
        for (int i = 0; i < size; i++) begin
            if (cand >= size) return 0;
            if (same_letter(c, sub ? SUB_ROM[cand] : TYPE_ROM[cand])) return cand + 1;
            cand = rom_next(sub, cand);
            if (cand == 0) return 0;
        end
        return 0;
    endfunction

    function automatic bit is_blank_ch(logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    task automatic set_err(logic [2:0] e);
        if (err_code == ST_OK) err_code = e;
    endtask

    task automatic give(logic [2:0] t, logic [4:0] s, logic [7:0] idx, logic done);
        res_v = 1'b1;
        res = '{type_code: t, subtype_code: s, status: ST_OK, entry_index: idx,
                list_done: done};
    endtask

    task automatic clear_entry();
        phase = PH_LEAD;
        tnode = 0;
        snode = 0;
        cur_type = 3'd0;
        pending_ws = 8'd0;
        pending_ws_v = 1'b0;
        name_open = 1'b0;
    endtask

    task automatic close_entry(bit comma, bit last);
        logic [4:0] s;
        s = name_open ? 5'(name_code(1, snode)) : SUB_WILD;
        if (cur_type == TYPE_WILD && s != SUB_WILD) begin
            set_err(ST_WILD_SUB);
        end else if (mode_single) begin
            if (comma || cur_type == TYPE_WILD || s == SUB_WILD) set_err(ST_SINGLE);
            else give(cur_type, s, 8'd0, 1'b1);
        end else if (types_seen >= 8'(MAX_LIST)) begin
            set_err(ST_OVERFLOW);
        end else if (comma && last) begin
            set_err(ST_SYNTAX);
        end else begin
            give(cur_type, s, types_seen, !comma);
            if (comma) begin
                types_seen++;
                clear_entry();
            end
        end
    endtask

    task automatic parse_char(logic [7:0] c, bit last);
        if (err_code != ST_OK) return;
        forever begin
            case (phase)
                PH_LEAD: begin
                    if (is_blank_ch(c)) return;
                    if ((c == CH_CR || c == CH_LF) && !last) begin
                        pending_ws = c; pending_ws_v = 1'b1; return;
                    end
                    if (c == CH_STAR) begin
                        cur_type = TYPE_WILD; phase = PH_AFTER_TYPE; return;
                    end
                    if (is_name(c)) begin
                        name_open = 1'b1;
                        tnode = trie_step(0, 0, 1, c);
                        phase = PH_TYPE;
                        return;
                    end
                    set_err(ST_SYNTAX);
                    return;
                end
                PH_TYPE: begin
                    if (is_name(c)) begin
                        tnode = trie_step(0, tnode, 0, c); return;
                    end
                    cur_type = 3'(name_code(0, tnode));
                    name_open = 1'b0;
                    phase = PH_AFTER_TYPE;
                end
                PH_AFTER_TYPE, PH_BEFORE_SUB, PH_AFTER_SUB: begin
                    if (is_blank_ch(c)) return;
                    if (c == CH_LF && !last) begin
                        pending_ws = c; pending_ws_v = 1'b1; return;
                    end
                    if (phase == PH_AFTER_TYPE) begin
                        if (c == CH_SLASH) phase = PH_BEFORE_SUB;
                        else set_err(ST_SYNTAX);
                    end else if (phase == PH_BEFORE_SUB) begin
                        if (c == CH_STAR) begin
                            name_open = 1'b0; phase = PH_AFTER_SUB;
                        end else if (is_name(c) || c == CH_UNDER) begin
                            name_open = 1'b1;
                            snode = trie_step(1, 0, 1, c);
                            phase = PH_SUB;
                        end else set_err(ST_SYNTAX);
                    end else begin
                        if (c == CH_SEMI) phase = PH_PARAM;
                        else if (c == CH_COMMA) close_entry(1, last);
                        else set_err(ST_SYNTAX);
                    end
                    return;
                end
                PH_SUB: begin
                    if (is_name(c) || c == CH_UNDER) begin
                        snode = trie_step(1, snode, 0, c); return;
                    end
                    phase = PH_AFTER_SUB;
                end
                PH_PARAM: begin
                    if (c == CH_COMMA) close_entry(1, last);
                    return;
                end
                default: begin
                    set_err(ST_SYNTAX);
                    return;
                end
            endcase
        end
    endtask

    task automatic predict_byte(logic [7:0] c, bit last);
        res_v = 1'b0;
        if (pending_ws_v) begin
            pending_ws_v = 1'b0;
            if (err_code == ST_OK) begin
                if (!((pending_ws == CH_CR && c == CH_LF) ||
                      (pending_ws == CH_LF && is_blank_ch(c))))
                    set_err(ST_SYNTAX);
            end
        end
        parse_char(c, last);
        if (last) begin
            if (err_code == ST_OK && !res_v) begin
                if (phase == PH_SUB || phase == PH_AFTER_SUB || phase == PH_PARAM)
                    close_entry(0, 1);
                else set_err(ST_SYNTAX);
            end
            if (err_code != ST_OK) begin
                res_v = 1'b1;
                res = '{type_code: 3'd0, subtype_code: 5'd0, status: err_code,
                        entry_index: types_seen, list_done: 1'b1};
            end
            clear_entry();
            types_seen = 8'd0;
            err_code = ST_OK;
        end
        if (res_v) expected_results.push_back(res);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        fail_count++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", field, got, want,
                 results_seen);
    endtask

    // result checker, watchdog, receiver stalls
    always @(posedge i_clk) begin
        t_out want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", expected_results.size());
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result count", results_seen, results_seen - 1);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.type_code != want.type_code)
                    report_mismatch("type_code", o_out_data.type_code, want.type_code);
                if (o_out_data.subtype_code != want.subtype_code)
                    report_mismatch("subtype_code", o_out_data.subtype_code,
                                    want.subtype_code);
                if (o_out_data.status != want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.entry_index != want.entry_index)
                    report_mismatch("entry_index", o_out_data.entry_index,
                                    want.entry_index);
                if (o_out_data.list_done != want.list_done)
                    report_mismatch("list_done", o_out_data.list_done, want.list_done);
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] c, bit last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{body_byte: c, body_last: last};
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(c, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_body();
        foreach (body[i]) send_byte(body[i], i == body.size() - 1);
    endtask

    task automatic send_text(string s);
        body.delete();
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
        send_body();
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(logic m);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mode_single = m;
    endtask

    task automatic add_text(string s, bit mix_case);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mix_case && (ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" && $urandom_range(2) == 0)
                ch = ch ^ 8'h20;
            body.push_back(ch);
        end
    endtask

    task automatic add_space(bit lead);
        case ($urandom_range(lead ? 6 : 5))
            0: add_text(" ", 0);
            1: add_text("\t", 0);
            2: add_text("\n ", 0);
            3: add_text("\n\t", 0);
            6: add_text("\r\n ", 0);
            default: ;
        endcase
    endtask

    task automatic build_body(int entries);
        string tn[] = '{"text", "message", "application", "multipart", "*", "*", "tex",
                        "texts", "x-foo", "appl1cation"};
        string sn[] = '{"plain", "pidf+xml", "sdp", "simple-message-summary", "cpim",
                        "cpl+xml", "rlmi+xml", "related", "lpidf+xml", "watcherinfo+xml",
                        "xpidf+xml", "xml+msrtc.pidf", "external-body", "mixed", "isup",
                        "*", "plai", "plainx", "a_b", "vnd.x"};
        body.delete();
        for (int e = 0; e < entries; e++) begin
            if (e > 0) add_text(",", 0);
            add_space(1);
            add_text(tn[$urandom_range(tn.size() - 1)], 1);
            add_space(0);
            add_text("/", 0);
            add_space(0);
            add_text(sn[$urandom_range(sn.size() - 1)], 1);
            add_space(0);
            if ($urandom_range(3) == 0) add_text(";q=0.7;level=1", 0);
        end
        // broken bodies: flipped byte, raw garbage, cut short, trailing comma
        case ($urandom_range(19))
            0, 1: body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
            2: begin
                body.delete();
                repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(255)));
            end
            3: if (body.size() > 1) body = body[0:$urandom_range(body.size() - 2)];
            4: add_text(",", 0);
            default: ;
        endcase
    endtask

    task automatic test_list_basics();
        send_text("text/plain");
        send_text(" \tApplication/PIDF+XML ;q=1,*/*");
        send_text("\r\n multipart/mixed\n\t, message/external-body ;a=b, text/xml+msrtc.pidf");
        send_text("tex/plainx,textual/a_b");
        send_text("*/plain");
        send_text("text/plain,");
        send_text("text/");
        send_text("text");
        send_text("\n");
        send_text("text/plain\r\n");
        send_text("\xff\x80/sdp");
        send_text("text/isup\n");
        send_text("text/plain;x=\x01\xfe");
    endtask

    task automatic test_list_overflow();
        body.delete();
        repeat (MAX_LIST + 2) add_text("*/*,", 0);
        add_text("text/plain", 0);
        send_body();
        body.delete();
        repeat (MAX_LIST - 1) add_text("a/b,", 0);
        add_text("message/cpim", 0);
        send_body();
    endtask

    task automatic test_single_type();
        write_mode(1'b1);
        send_text("application/sdp");
        send_text("text/plain, text/plain");
        send_text("*/*");
        send_text("text/*");
        send_text("*/cpim");
        send_text("multipart/related;type=x");
        write_mode(1'b0);
    endtask

    task automatic test_random_traffic(int items, int s_pct, int r_pct);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = bytes_sent + items;
        while (bytes_sent < target) begin
            if ($urandom_range(24) == 0) write_mode($urandom_range(1));
            // let everything drain now and then before the next body
            if ($urandom_range(15) == 0) wait_idle();
            build_body(mode_single ? ($urandom_range(5) == 0 ? 2 : 1) : $urandom_range(1, 4));
            send_body();
        end
    endtask

    initial begin
        mode_single = 1'b0;
        types_seen = 8'd0;
        err_code = ST_OK;
        clear_entry();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_mode(1'b0);
        test_list_basics();
        test_single_type();
        test_list_overflow();
        test_random_traffic(310, 17, 76);
        test_random_traffic(310, 76, 17);
        test_random_traffic(310, 0, 0);
        wait_idle();
        $display("Sent %0d body bytes in list and single mode, checked %0d results,",
                 bytes_sent, results_seen);
        $display("with sender and receiver stalls in both directions and list overflow.");
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
